@@ src/dqb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dqb_pkg;

  // Label capacity and fixed message framing.
  localparam int unsigned MaxLabelDef = 32;
  localparam logic [7:0]  DotChar     = 8'h2E;
  localparam int unsigned StepW       = 4;
  localparam logic [StepW-1:0] HdrLast   = StepW'(11);
  localparam logic [StepW-1:0] CloseLast = StepW'(4);

  // Queue depths between the parts.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgQueryId    = 2'd0,
    CfgRecursion  = 2'd1,
    CfgQueryType  = 2'd2,
    CfgQueryClass = 2'd3
  } cfg_idx_e;

  // Register reset values.
  localparam logic [15:0] QueryIdRst    = 16'd123;
  localparam logic        RecursionRst  = 1'b1;
  localparam logic [15:0] QueryTypeRst  = 16'd1;
  localparam logic [15:0] QueryClassRst = 16'd1;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic       hdr;
    logic       last;
    logic [7:0] ch;
  } cmd_t;

  // One result byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       msg_end;
    logic       ovf;
  } out_t;

endpackage

`default_nettype wire

@@ src/dqb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dqb_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output      logic         full,
  input  wire logic [7:0]   name_char_i,
  input  wire logic         name_end_i,
  output      logic         cmd_valid_o,
  input  wire logic         cmd_ready_i,
  output      dqb_pkg::cmd_t cmd_o
);
  import dqb_pkg::*;

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            hdr_sent_q;
  logic            wr_en, rd_en;

  // Accept when the command queue has room; take when the back is ready.
  assign full        = (cnt_q == CntW'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push & ~full;
  assign rd_en       = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  // Queue storage: payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= '{hdr: ~hdr_sent_q, last: name_end_i, ch: name_char_i};
    end
  end

  // Pointers, fill count and the header tracking of the current name.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      hdr_sent_q <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr_q   <= (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
        hdr_sent_q <= ~name_end_i;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!wr_en && rd_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dqb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dqb_back #(
  parameter int unsigned MaxLabel = dqb_pkg::MaxLabelDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output      logic          cmd_ready_o,
  input  wire dqb_pkg::cmd_t cmd_i,
  input  wire logic [15:0]   query_id_i,
  input  wire logic          recursion_desired_i,
  input  wire logic [15:0]   query_type_i,
  input  wire logic [15:0]   query_class_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      dqb_pkg::out_t out_o
);
  import dqb_pkg::*;

  localparam int unsigned CntW = $clog2(MaxLabel + 1);
  localparam int unsigned IdxW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;

  typedef enum logic [2:0] {
    StIdle,
    StHdr,
    StLen,
    StData,
    StClose
  } state_e;

  state_e          state_q;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0] idx_q;
  logic [CntW-1:0] cnt_q, cnt_new, cnt_m1;
  logic            ovf_q, flush_q, close_q;
  logic [7:0]      store_q [MaxLabel];
  logic            is_dot, store_en, room, advance;
  logic [7:0]      hdr_byte, close_byte;

  // Where to go once the header, if any, is out.
  function automatic state_e after_hdr(input logic flush, input logic close,
                                       input logic [CntW-1:0] cnt);
    state_e nxt;
    if (flush && cnt != '0) begin
      nxt = StLen;
    end else if (close) begin
      nxt = StClose;
    end else begin
      nxt = StIdle;
    end
    return nxt;
  endfunction

  // Classification of the command at the head of the queue.
  assign cmd_ready_o = (state_q == StIdle);
  assign is_dot      = (cmd_i.ch == DotChar);
  assign store_en    = cmd_valid_i & cmd_ready_o & ~is_dot;
  assign room        = (cnt_q < CntW'(MaxLabel));
  assign cnt_new     = (store_en && room) ? cnt_q + CntW'(1) : cnt_q;
  assign cnt_m1      = cnt_q - CntW'(1);

  // Header bytes by position.
  always_comb begin
    unique case (step_q)
      StepW'(0): hdr_byte = query_id_i[7:0];
      StepW'(1): hdr_byte = query_id_i[15:8];
      StepW'(2): hdr_byte = {7'd0, recursion_desired_i};
      StepW'(5): hdr_byte = 8'h01;
      default:   hdr_byte = 8'h00;
    endcase
  end

  // Closing bytes: root label, type and class in network order.
  always_comb begin
    unique case (step_q)
      StepW'(1): close_byte = query_type_i[15:8];
      StepW'(2): close_byte = query_type_i[7:0];
      StepW'(3): close_byte = query_class_i[15:8];
      StepW'(4): close_byte = query_class_i[7:0];
      default:   close_byte = 8'h00;
    endcase
  end

  // Result byte for the current state.
  always_comb begin
    out_valid_o = 1'b1;
    out_o       = '{data: 8'h00, msg_end: 1'b0, ovf: 1'b0};
    unique case (state_q)
      StHdr:   out_o.data = hdr_byte;
      StLen: begin
        out_o.data = 8'(cnt_q);
        out_o.ovf  = ovf_q;
      end
      StData:  out_o.data = store_q[idx_q];
      StClose: begin
        out_o.data    = close_byte;
        out_o.msg_end = (step_q == CloseLast);
      end
      default: out_valid_o = 1'b0;
    endcase
  end

  assign advance = out_valid_o & out_ready_i;

  // Label store: written at the fill count, no reset.
  always_ff @(posedge clk_i) begin
    if (store_en && room) begin
      store_q[cnt_q[IdxW-1:0]] <= cmd_i.ch;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      flush_q <= 1'b0;
      close_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            flush_q <= is_dot | cmd_i.last;
            close_q <= cmd_i.last;
            step_q  <= '0;
            idx_q   <= '0;
            cnt_q   <= cnt_new;
            if (store_en && !room) begin
              ovf_q <= 1'b1;
            end
            state_q <= cmd_i.hdr ? StHdr : after_hdr(is_dot | cmd_i.last, cmd_i.last, cnt_new);
          end
        end
        StHdr: begin
          if (advance) begin
            if (step_q == HdrLast) begin
              step_q  <= '0;
              state_q <= after_hdr(flush_q, close_q, cnt_q);
            end else begin
              step_q <= step_q + StepW'(1);
            end
          end
        end
        StLen: begin
          if (advance) begin
            idx_q   <= '0;
            state_q <= StData;
          end
        end
        StData: begin
          if (advance) begin
            idx_q <= idx_q + IdxW'(1);
            if (CntW'(idx_q) == cnt_m1) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              step_q  <= '0;
              state_q <= close_q ? StClose : StIdle;
            end
          end
        end
        StClose: begin
          if (advance) begin
            step_q <= step_q + StepW'(1);
            if (step_q == CloseLast) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/dqb_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dqb_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire dqb_pkg::out_t in_i,
  output      logic          empty,
  input  wire logic          pop,
  output      dqb_pkg::out_t out_o
);
  import dqb_pkg::*;

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  out_t            mem_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign in_ready_o = (cnt_q != CntW'(OutDepth));
  assign empty      = (cnt_q == '0);
  assign wr_en      = in_valid_i & in_ready_o;
  assign rd_en      = pop & ~empty;
  assign out_o      = mem_q[rd_ptr_q];

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= in_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!wr_en && rd_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dns_query_builder_core.sv @@
// Channel   Handshake            Payload
// input     push / full          name_char_i, name_end_i
// result    empty / pop          out_byte_o, message_end_o, label_overflow_o
// config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A plain character is taken by the sequencer while it is idle; a label of n
// stored characters flushes as n + 1 bytes, the header as 12 bytes and the
// closing bytes as 5, one result byte per cycle while the result queue has
// room. Reset clears all control state at once; there is no clearing pass.
// Input stalls only when the two-entry command queue is full, and the
// sequencer stalls on a full result queue.
`timescale 1ns / 1ps
`default_nettype none

module dns_query_builder_core #(
  parameter int unsigned MaxLabel = dqb_pkg::MaxLabelDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output      logic                      full,
  input  wire logic [7:0]                name_char_i,
  input  wire logic                      name_end_i,
  output      logic                      empty,
  input  wire logic                      pop,
  output      logic [7:0]                out_byte_o,
  output      logic                      message_end_o,
  output      logic                      label_overflow_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [dqb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [15:0]               cfg_wdata_i
);
  import dqb_pkg::*;

  logic [15:0] query_id_q, query_type_q, query_class_q;
  logic        recursion_q;
  logic        cmd_valid, cmd_ready, res_valid, res_ready;
  cmd_t        cmd;
  out_t        res, head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_id_q    <= QueryIdRst;
      recursion_q   <= RecursionRst;
      query_type_q  <= QueryTypeRst;
      query_class_q <= QueryClassRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgQueryId:    query_id_q    <= cfg_wdata_i;
        CfgRecursion:  recursion_q   <= cfg_wdata_i[0];
        CfgQueryType:  query_type_q  <= cfg_wdata_i;
        CfgQueryClass: query_class_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Front: accepts characters and queues them with their header flag.
  dqb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .name_char_i (name_char_i),
    .name_end_i  (name_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: buffers labels and emits the message bytes.
  dqb_back #(
    .MaxLabel (MaxLabel)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_valid_i         (cmd_valid),
    .cmd_ready_o         (cmd_ready),
    .cmd_i               (cmd),
    .query_id_i          (query_id_q),
    .recursion_desired_i (recursion_q),
    .query_type_i        (query_type_q),
    .query_class_i       (query_class_q),
    .out_valid_o         (res_valid),
    .out_ready_i         (res_ready),
    .out_o               (res)
  );

  // Result queue towards the consumer.
  dqb_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_ready_o (res_ready),
    .in_i       (res),
    .empty      (empty),
    .pop        (pop),
    .out_o      (head)
  );

  assign out_byte_o       = head.data;
  assign message_end_o    = head.msg_end;
  assign label_overflow_o = head.ovf;

endmodule

`default_nettype wire

@@ verif/dqb_stream_checker.sv @@
`timescale 1ns / 1ps

module dqb_stream_checker #(
  parameter int unsigned MaxLabel = dqb_pkg::MaxLabelDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  input  wire logic                          full,
  input  wire logic [7:0]                    name_char_i,
  input  wire logic                          name_end_i,
  input  wire logic                          empty,
  input  wire logic                          pop,
  input  wire logic [7:0]                    out_byte_o,
  input  wire logic                          message_end_o,
  input  wire logic                          label_overflow_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [dqb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  output int                                 err_count_o,
  output int                                 pending_o
);

  import dqb_pkg::*;

  // The header announces exactly one question.
  localparam logic [7:0] QuestionCount = 8'd1;
  localparam int         MaxReports    = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       msg_end;
    logic       ovf;
  } msg_byte_t;

  // Bytes of the query message still owed by the block, oldest first.
  msg_byte_t   msg_bytes_q[$];
  msg_byte_t   want_b;

  // Shadow copy of the registers.
  logic [15:0] id_r    = QueryIdRst;
  logic        rd_r    = RecursionRst;
  logic [15:0] type_r  = QueryTypeRst;
  logic [15:0] class_r = QueryClassRst;

  // Shadow copy of the name assembly state.
  logic        hdr_sent = 1'b0;
  logic [7:0]  label_buf [MaxLabel];
  logic [5:0]  label_len = '0;
  logic        ovf_seen  = 1'b0;

  int          n_err = 0;

  function automatic void queue_byte(logic [7:0] b, logic e, logic o);
    msg_bytes_q.push_back('{data: b, msg_end: e, ovf: o});
  endfunction

  // A pending label goes out as its length byte followed by its characters.
  function automatic void flush_label();
    if (label_len == '0) return;
    queue_byte(8'(label_len), 1'b0, ovf_seen);
    for (int i = 0; i < int'(label_len); i++) queue_byte(label_buf[i], 1'b0, 1'b0);
    label_len = '0;
    ovf_seen  = 1'b0;
  endfunction

  // Works out every message byte that one name character releases.
  function automatic void build_query_bytes(logic [7:0] ch, logic last);
    if (!hdr_sent) begin
      queue_byte(id_r[7:0], 1'b0, 1'b0);
      queue_byte(id_r[15:8], 1'b0, 1'b0);
      queue_byte({7'b0, rd_r}, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(QuestionCount, 1'b0, 1'b0);
      repeat (6) queue_byte(8'h00, 1'b0, 1'b0);
      hdr_sent = 1'b1;
    end

    if (ch == DotChar) begin
      flush_label();
    end else begin
      // Characters past the label capacity are dropped but remembered.
      if (label_len < MaxLabel) begin
        label_buf[label_len] = ch;
        label_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (last) flush_label();
    end

    // The name closes with a zero byte, then type and class, high byte first.
    if (last) begin
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(type_r[15:8], 1'b0, 1'b0);
      queue_byte(type_r[7:0], 1'b0, 1'b0);
      queue_byte(class_r[15:8], 1'b0, 1'b0);
      queue_byte(class_r[7:0], 1'b1, 1'b0);
      hdr_sent  = 1'b0;
      label_len = '0;
      ovf_seen  = 1'b0;
    end
  endfunction

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      n_err++;
      if (n_err <= MaxReports) begin
        $error("%s: expected %0h, actual %0h", fname, want, got);
      end
    end
  endfunction

  // Results are compared before the same edge's item is predicted, since an
  // item cannot release a byte at the edge where it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_r      = QueryIdRst;
      rd_r      = RecursionRst;
      type_r    = QueryTypeRst;
      class_r   = QueryClassRst;
      hdr_sent  = 1'b0;
      label_len = '0;
      ovf_seen  = 1'b0;
      msg_bytes_q.delete();
    end else begin
      if (pop && !empty) begin
        if (msg_bytes_q.size() == 0) begin
          n_err++;
          if (n_err <= MaxReports) begin
            $error("out_byte: no byte expected, actual %0h", out_byte_o);
          end
        end else begin
          want_b = msg_bytes_q.pop_front();
          check_field("out_byte", want_b.data, out_byte_o);
          check_field("message_end", {7'b0, want_b.msg_end}, {7'b0, message_end_o});
          check_field("label_overflow", {7'b0, want_b.ovf}, {7'b0, label_overflow_o});
        end
      end

      if (push && !full) build_query_bytes(name_char_i, name_end_i);

      // Register writes must come only while the block is idle; the block does not enforce it.
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgQueryId:    id_r    = cfg_wdata_i;
          CfgRecursion:  rd_r    = cfg_wdata_i[0];
          CfgQueryType:  type_r  = cfg_wdata_i;
          CfgQueryClass: class_r = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o   = msg_bytes_q.size();
    err_count_o = n_err;
  end

endmodule

@@ verif/dns_query_builder_core_tb.sv @@
`timescale 1ns / 1ps

module dns_query_builder_core_tb;

  import dqb_pkg::*;

  localparam int          ClkPeriod   = 8;
  localparam int          ResetCycles = 6;
  localparam int          RandomItems = 140;
  localparam int          Phases      = 5;
  localparam int          DrainCycles = 40;
  localparam int unsigned CycleLimit  = 3_000_000;

  typedef logic [7:0] name_q_t[$];

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic [7:0]         name_char_i = '0;
  logic               name_end_i  = 1'b0;
  logic               pop         = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = CfgQueryId;
  logic [15:0]        cfg_wdata_i = '0;

  logic               full;
  logic               empty;
  logic [7:0]         out_byte_o;
  logic               message_end_o;
  logic               label_overflow_o;

  int                 err_count;
  int                 pending;

  int unsigned        cycle_cnt  = 0;
  int unsigned        items_sent = 0;
  int unsigned        stall_left = 0;
  bit                 tx_steady  = 1'b0;
  bit                 rx_steady  = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  dns_query_builder_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .name_char_i      (name_char_i),
    .name_end_i       (name_end_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .message_end_o    (message_end_o),
    .label_overflow_o (label_overflow_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  dqb_stream_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .name_char_i      (name_char_i),
    .name_end_i       (name_end_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .message_end_o    (message_end_o),
    .label_overflow_o (label_overflow_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  // Result side: pops with random stalls, or every cycle in a steady phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_steady) begin
      pop <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = idle_len();
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Offers one item and returns at the edge that takes it.
  task automatic send_item(logic [7:0] ch, logic last);
    int unsigned gap;
    gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    name_char_i <= ch;
    name_end_i  <= last;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic send_name(name_q_t chars);
    for (int i = 0; i < chars.size(); i++) send_item(chars[i], i == chars.size() - 1);
  endtask

  // Any byte but the dot can sit inside a label.
  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == DotChar) c = 8'h2D;
    return c;
  endfunction

  // Mostly well-formed names with random content; some labels run past
  // capacity, some are empty, and a few names are plain noise full of dots.
  task automatic build_random_name(output name_q_t q);
    int unsigned n_labels;
    int unsigned len;
    int unsigned r;
    q = {};
    if ($urandom_range(0, 99) < 12) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        if ($urandom_range(0, 2) == 0) q.push_back(DotChar);
        else q.push_back(label_char());
      end
    end else begin
      n_labels = $urandom_range(1, 4);
      for (int l = 0; l < n_labels; l++) begin
        r = $urandom_range(0, 99);
        if (r < 8) len = 0;
        else if (r < 18) len = $urandom_range(MaxLabelDef - 2, MaxLabelDef + 8);
        else len = $urandom_range(1, 10);
        if (l > 0) q.push_back(DotChar);
        repeat (len) q.push_back(label_char());
      end
      if ($urandom_range(0, 3) == 0) q.push_back(DotChar);
    end
    if (q.size() == 0) q.push_back(DotChar);
  endtask

  // Writes all four registers on consecutive edges; junk above bit 0 of the
  // recursion flag must be ignored.
  task automatic write_regs(logic [15:0] id, logic rd, logic [15:0] qtype,
                            logic [15:0] qclass);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgQueryId;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_idx_i   <= CfgRecursion;
    cfg_wdata_i <= {junk[15:1], rd};
    @(posedge clk_i);
    cfg_idx_i   <= CfgQueryType;
    cfg_wdata_i <= qtype;
    @(posedge clk_i);
    cfg_idx_i   <= CfgQueryClass;
    cfg_wdata_i <= qclass;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Holds the input back until every byte owed has come, then lets the
  // block settle.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    name_q_t     name_q;
    int unsigned target;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A lone dot, then leading, double and trailing dots in one name.
    name_q = {DotChar};
    send_name(name_q);
    name_q = {DotChar, 8'h61, DotChar, DotChar, 8'h62, DotChar};
    send_name(name_q);
    // Zero and all-ones characters are ordinary label bytes.
    name_q = {8'h00, 8'hFF};
    send_name(name_q);
    name_q = {8'h77};
    send_name(name_q);

    // Random names over several register settings, extremes first.
    for (int p = 0; p < Phases; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1:       write_regs(16'h0000, 1'b0, 16'h0000, 16'h0000);
          2:       write_regs(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
          default: write_regs(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      target    = items_sent + RandomItems / Phases;
      while (items_sent < target) begin
        build_random_name(name_q);
        send_name(name_q);
      end
    end

    rx_steady = 1'b0;
    wait_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/dqb_pkg.sv
src/dqb_front.sv
src/dqb_back.sv
src/dqb_out_fifo.sv
src/dns_query_builder_core.sv
verif/dqb_stream_checker.sv
verif/dns_query_builder_core_tb.sv
